[rtl/fqdiv_pkg.sv]
// shared types and constants for the q8.56 signed divider
package fqdiv_pkg;

	localparam int QW    = 64;
	localparam int StepW = $clog2(QW);

	typedef logic [QW-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_START,
		ST_DIV,
		ST_ROUND,
		ST_FINISH
	} fqdiv_state_t;

	typedef struct packed {
		logic done;
		logic big;
	} fqdiv_stat_t;

	function automatic word_t magnitude(input word_t v);
		magnitude = v[QW-1] ? (~v + word_t'(1)) : v;
	endfunction

endpackage

[rtl/fqdiv_core.sv]
// iterative restoring divider core, one quotient bit per cycle
module fqdiv_core
	import fqdiv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  word_t       num_hi,
	input  word_t       num_lo,
	input  word_t       den,
	output fqdiv_stat_t stat,
	output word_t       quo
);

	logic             busy_q;
	logic [StepW-1:0] cnt_q;
	logic             big_q;
	word_t            rem_q;
	word_t            lo_q;
	word_t            den_q;

	logic [QW:0] rem_sh;
	logic        ge;
	logic [QW:0] diff;

	assign rem_sh = {rem_q, lo_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + StepW'(1);
			if (cnt_q == StepW'(QW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
			den_q <= den;
			big_q <= num_hi >= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[QW-1:0] : rem_sh[QW-1:0];
			lo_q  <= {lo_q[QW-2:0], ge};
		end
	end

	assign stat.done = busy_q && (cnt_q == StepW'(QW - 1));
	assign stat.big  = big_q;
	assign quo       = lo_q;

endmodule

[rtl/fixed_q8_56_signed_divider_top.sv]
// signed q8.56 fixed-point divider top level with stream ports
// an input transfer passes through the magnitude, start, divide, round and finish states to result valid
// one item in flight at a time, set by the 64-step shared subtract/compare loop
// input ready only while idle; a finished result waits in the output register
// arst_n clears the sequencer and output valid, data registers are not reset
module fixed_q8_56_signed_divider_top
	import fqdiv_pkg::*;
#(
	parameter int FRACTION_BITS = 56
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // dividend[63:0], divisor[127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // quotient[63:0]
	output logic [1:0]   m_tuser   // overflow[0], div_by_zero[1]
);

	localparam int Up      = FRACTION_BITS + 1;
	localparam int HiShift = QW - Up;

	fqdiv_state_t state_q, state_d;

	word_t a_q, b_q, ma_q, mb_q, qmag_q, tdata_q;
	logic  neg_q, zero_q, ovf_q, m_tvalid_q;
	logic [1:0] tuser_q;

	logic        core_start, load_out;
	fqdiv_stat_t stat;
	word_t       quo, num_hi, num_lo;

	logic [QW:0] q_rnd;
	word_t       q_lim;
	logic        q_ovf;
	word_t       res;

	assign num_hi = ma_q >> HiShift;
	assign num_lo = ma_q << Up;

	fqdiv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.num_hi (num_hi),
		.num_lo (num_lo),
		.den    (mb_q),
		.stat   (stat),
		.quo    (quo)
	);

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		core_start = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG: begin
				state_d = ST_START;
			end
			ST_START: begin
				core_start = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				if (stat.done) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// round the magnitude half up on the guard bit (half away from zero), then clamp
	assign q_rnd = {2'b00, quo[QW-1:1]} + {{QW{1'b0}}, quo[0]};
	assign q_lim = neg_q ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
	assign q_ovf = stat.big || (q_rnd[QW-1:0] > q_lim);
	assign res   = neg_q ? (word_t'(0) - qmag_q) : qmag_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			a_q <= s_tdata[QW-1:0];
			b_q <= s_tdata[2*QW-1:QW];
		end
		if (state_q == ST_MAG) begin
			ma_q   <= magnitude(a_q);
			mb_q   <= magnitude(b_q);
			neg_q  <= a_q[QW-1] ^ b_q[QW-1];
			zero_q <= b_q == '0;
		end
		if (state_q == ST_ROUND) begin
			qmag_q <= q_ovf ? q_lim : q_rnd[QW-1:0];
			ovf_q  <= q_ovf;
		end
		if (load_out) begin
			tdata_q <= zero_q ? '0 : res;
			tuser_q <= {zero_q, ovf_q && !zero_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

`ifndef SYNTH
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == ST_DIV)
		else $error("divider core finished outside the divide phase");

	a_accept_to_mag: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_MAG)
		else $error("input transfer did not start the magnitude phase");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("overflow and div_by_zero both set");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0)
		else $error("div_by_zero result is not zero");

	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid && state_q == ST_IDLE)
		else $error("result load did not present output and return to idle");
`endif

endmodule

[verif/fqdiv_quotient_checker.sv]
// result checker for the q8.56 signed divider: predicts each quotient and compares transfers
module fqdiv_quotient_checker
	import fqdiv_pkg::*;
#(
	parameter int FRACTION_BITS = 56
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [63:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           error_count,
	output int           quotients_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		word_t quotient;
		logic  overflow;
		logic  div_by_zero;
	} quot_t;

	typedef struct packed {
		word_t dividend;
		word_t divisor;
		quot_t res;
	} quot_due_t;

	quot_due_t due_q[$];
	int        errs = 0;

	function automatic quot_t divide_q856(input word_t dividend, input word_t divisor);
		quot_t        r;
		logic         neg;
		word_t        mag_a;
		word_t        mag_b;
		word_t        q;
		word_t        lim;
		logic [127:0] num;
		logic [127:0] quo;
		r = '0;
		if (divisor == '0) begin
			r.div_by_zero = 1'b1;
			return r;
		end
		neg   = dividend[QW-1] ^ divisor[QW-1];
		mag_a = dividend[QW-1] ? -dividend : dividend;
		mag_b = divisor[QW-1] ? -divisor : divisor;
		// one guard bit below the result lsb
		num = {64'd0, mag_a} << (FRACTION_BITS + 1);
		quo = num / {64'd0, mag_b};
		q   = quo[63:0];
		q   = (q >> 1) + word_t'(q[0]);
		lim = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		if ((|quo[127:64]) || q > lim) begin
			q          = lim;
			r.overflow = 1'b1;
		end
		r.quotient = neg ? -q : q;
		return r;
	endfunction

	always @(posedge clk) begin
		quot_due_t want;
		quot_t     got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want.dividend = s_tdata[63:0];
				want.divisor  = s_tdata[127:64];
				want.res      = divide_q856(s_tdata[63:0], s_tdata[127:64]);
				due_q.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.quotient    = m_tdata;
				got.overflow    = m_tuser[0];
				got.div_by_zero = m_tuser[1];
				if (due_q.size() == 0) begin
					$display("%0t: unexpected transfer: expected none, actual quotient %h flags %b",
						$time, m_tdata, m_tuser);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (got.quotient !== want.res.quotient) begin
						$display("%0t: quotient of %h / %h: expected %h, actual %h", $time,
							want.dividend, want.divisor, want.res.quotient, got.quotient);
						errs++;
					end
					if (got.overflow !== want.res.overflow) begin
						$display("%0t: overflow of %h / %h: expected %b, actual %b", $time,
							want.dividend, want.divisor, want.res.overflow, got.overflow);
						errs++;
					end
					if (got.div_by_zero !== want.res.div_by_zero) begin
						$display("%0t: div_by_zero of %h / %h: expected %b, actual %b", $time,
							want.dividend, want.divisor, want.res.div_by_zero, got.div_by_zero);
						errs++;
					end
				end
			end
		end
		quotients_due <= due_q.size();
		error_count   <= errs;
	end

endmodule

[verif/tb_fixed_q8_56_signed_divider_top.sv]
// testbench top for the q8.56 signed divider: clock, reset, stream stimulus and verdict
module tb_fixed_q8_56_signed_divider_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fqdiv_pkg::*;

	localparam word_t ONE          = 64'h0100_0000_0000_0000;
	localparam word_t MIN_Q        = 64'h8000_0000_0000_0000;
	localparam word_t MAX_Q        = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int    RANDOM_ITEMS = 1225;
	localparam int    HOLD_CYCLES  = 400;
	localparam int    DRAIN_CYCLES = 80;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_EVERY_THIRD
	} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           error_count;
	int           quotients_due;
	bit           hold_request = 1'b0;

	fixed_q8_56_signed_divider_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fqdiv_quotient_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.error_count   (error_count),
		.quotients_due (quotients_due)
	);

	always #5 clk = ~clk;

	task automatic offer(input word_t dividend, input word_t divisor);
		s_tdata  <= {divisor, dividend};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (quotients_due != 0);
	endtask

	function automatic word_t pick_operand();
		word_t v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: ;
			1: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 64'd1;
					2: v = '1;
					3: v = MIN_Q;
					4: v = MAX_Q;
					default: v = ONE;
				endcase
			end
			default: begin
				v = v >> $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic word_t pick_divisor(input word_t dividend);
		word_t mag;
		word_t v;
		mag = dividend[63] ? -dividend : dividend;
		case ($urandom_range(0, 29))
			0: v = '0;
			1, 2, 3, 4: begin
				// around the saturation edge, |a| / |b| close to 128
				v = (mag >> 7) + word_t'($urandom_range(0, 4)) - word_t'(2);
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = pick_operand();
		endcase
		return v;
	endfunction

	initial begin
		int    sent;
		int    burst;
		bit    paused;
		word_t a;
		sent   = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer('0, ONE);
		offer(ONE, '0);
		offer(MIN_Q, '0);
		offer('0, '0);
		offer(MAX_Q, MAX_Q);
		offer(MIN_Q, MIN_Q);
		offer(MIN_Q, -ONE);
		offer(MIN_Q, ONE);
		offer(MAX_Q, 64'd1);
		offer(MIN_Q, 64'd1);
		offer(MAX_Q, '1);
		offer(64'd1, MAX_Q);
		offer('1, MAX_Q);
		offer(MAX_Q, MIN_Q);
		offer(MIN_Q, MAX_Q);
		offer(ONE, 3 * ONE);
		offer(-ONE, 3 * ONE);
		offer(64'd1, 2 * ONE);
		offer('1, 2 * ONE);
		offer(-(ONE << 6), ONE >> 1);
		offer(ONE << 6, ONE >> 1);
		offer('1, '1);
		offer(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		offer(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		wait_drained();

		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				a = pick_operand();
				offer(a, pick_divisor(a));
				sent++;
				if (sent >= 300)
					hold_request = 1'b1;
			end
			if (sent >= 700 && !paused) begin
				paused = 1'b1;
				wait_drained();
			end else if ((sent < 900 || sent >= 1000) && $urandom_range(0, 3) != 0) begin
				// gap lengths spread over the whole division pass
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 90)) @(posedge clk);
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		rx_mode_t mode;
		int       len;
		int       cyc;
		bit       hold_done;
		bit       rdy;
		cyc       = 0;
		hold_done = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			len  = $urandom_range(20, 300);
			repeat (len) begin
				if (hold_request && !hold_done) begin
					// long back-pressure so the block fills and stalls its input
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					RX_ALWAYS:   rdy = 1'b1;
					RX_COIN:     rdy = 1'($urandom_range(0, 1));
					RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
					default:     rdy = (cyc % 3 == 0);
				endcase
				m_tready <= rdy;
				cyc++;
				@(posedge clk);
			end
		end
	end

	initial begin
		#8ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/fqdiv_pkg.sv
rtl/fqdiv_core.sv
rtl/fixed_q8_56_signed_divider_top.sv
verif/fqdiv_quotient_checker.sv
verif/tb_fixed_q8_56_signed_divider_top.sv
